>>> hw/rtl/fbev_pkg.sv
// shared types and constants of the factor base entry validator
// no dependencies
package fbev_pkg;

  localparam int INDEX_BITS = 32;
  localparam int MOD_W      = 32;
  localparam int ROOT_W     = 32;
  localparam int FLAG_W     = 8;
  localparam int DIV_W      = 17;   // trial divisor, up to just past sqrt(2^32)
  localparam int DSQ_W      = 2 * DIV_W;
  localparam int DIV_STEPS  = MOD_W;
  localparam int DCNT_W     = $clog2(DIV_STEPS);

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_BELOW2    = 3'd1;
  localparam logic [2:0] ERR_UNORDERED = 3'd2;
  localparam logic [2:0] ERR_ROOT      = 3'd3;
  localparam logic [2:0] ERR_FLAG      = 3'd4;
  localparam logic [2:0] ERR_NOT_PP    = 3'd5;
  localparam logic [2:0] ERR_POWER     = 3'd6;
  localparam logic [2:0] ERR_DISAGREE  = 3'd7;

  localparam logic [1:0] KIND_INVALID = 2'd0;
  localparam logic [1:0] KIND_PRIME   = 2'd1;
  localparam logic [1:0] KIND_POWER   = 2'd2;

  localparam logic [1:0] POL_PRIMES    = 2'd0;
  localparam logic [1:0] POL_EXTERNAL  = 2'd1;
  localparam logic [1:0] POL_GENERATED = 2'd2;
  localparam logic [1:0] POL_UNKNOWN   = 2'd3;

  localparam logic REG_POLICY = 1'b0;
  localparam logic REG_FLAGS  = 1'b1;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHECK = 7'b0000010,
    S_TRIAL = 7'b0000100,
    S_TWAIT = 7'b0001000,
    S_STRIP = 7'b0010000,
    S_SWAIT = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  typedef struct packed {
    logic load;
    logic check;
    logic div_start;
    logic take_quot;
    logic step_d;
    logic set_prime;
    logic set_wres;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic need_loop;
    logic dsq_over;
    logic div_done;
    logic rem_zero;
    logic out_free;
  } status_t;

endpackage

>>> hw/rtl/fbev_div.sv
// restoring divider, one quotient bit per cycle
// depends on fbev_pkg
module fbev_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [fbev_pkg::MOD_W-1:0] dividend,
  input  logic [fbev_pkg::DIV_W-1:0] divisor,
  output logic                       done,
  output logic [fbev_pkg::MOD_W-1:0] quotient,
  output logic [fbev_pkg::DIV_W-1:0] remainder
);
  import fbev_pkg::*;

  logic              busy;
  logic [DCNT_W-1:0] cnt;
  logic [MOD_W-1:0]  quo;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W:0]    rem_sh;
  logic [DIV_W:0]    rem_nx;
  logic              ge;

  assign rem_sh = {rem, quo[MOD_W-1]};
  assign ge     = rem_sh >= {1'b0, divisor};
  assign rem_nx = ge ? rem_sh - {1'b0, divisor} : rem_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        quo  <= dividend;
        rem  <= '0;
      end else if (busy) begin
        rem <= rem_nx[DIV_W-1:0];
        quo <= {quo[MOD_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == DCNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;
endmodule

>>> hw/rtl/fbev_dpath.sv
// datapath: entry registers, structural checks, trial division, verdict register
// depends on fbev_pkg and fbev_div
module fbev_dpath (
  input  logic                        clk,
  input  logic                        rst,
  input  fbev_pkg::cmd_t              cmd,
  output fbev_pkg::status_t           sts,
  input  logic [1:0]                  policy,
  input  logic                        flags_present,
  input  logic [fbev_pkg::MOD_W-1:0]  modulus,
  input  logic [fbev_pkg::ROOT_W-1:0] root_code,
  input  logic [fbev_pkg::FLAG_W-1:0] power_flag,
  input  logic                        last,
  input  logic                        out_stall,
  output logic                        out_valid,
  output logic                        passed,
  output logic [2:0]                  error_code,
  output logic [31:0]                 error_index
);
  import fbev_pkg::*;

  logic [MOD_W-1:0]      q;
  logic [ROOT_W-1:0]     r;
  logic [FLAG_W-1:0]     flag;
  logic                  is_last;
  logic [MOD_W-1:0]      prev_mod;
  logic [INDEX_BITS-1:0] idx;
  logic [2:0]            s_err;
  logic [INDEX_BITS-1:0] s_at;
  logic [2:0]            c_err;
  logic [INDEX_BITS-1:0] c_at;
  logic [MOD_W-1:0]      cached_mod;
  logic [1:0]            cached_kind;
  logic                  cache_valid;
  logic                  pr;
  logic                  pw;
  logic [DIV_W-1:0]      d;
  logic [DSQ_W-1:0]      dsq;
  logic [MOD_W-1:0]      w;

  logic                  div_done;
  logic [MOD_W-1:0]      quot;
  logic [DIV_W-1:0]      rem;

  logic [1:0]            pol;
  logic                  flagged;
  logic                  need_class;
  logic [2:0]            s_e;
  logic [1:0]            kind_new;
  logic [1:0]            kind;
  logic [2:0]            c_e;
  logic                  cache_upd;
  logic [2:0]            s_err_next;
  logic [INDEX_BITS-1:0] s_at_next;
  logic [2:0]            c_err_next;
  logic [INDEX_BITS-1:0] c_at_next;
  logic [2:0]            code;
  logic [INDEX_BITS-1:0] code_at;

  fbev_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (w),
    .divisor  (d),
    .done     (div_done),
    .quotient (quot),
    .remainder(rem)
  );

  assign pol        = (policy == POL_UNKNOWN) ? POL_PRIMES : policy;
  assign flagged    = flags_present && (flag != '0);
  assign need_class = !cache_valid || (q != cached_mod);

  always_comb begin
    // structural checks
    s_e = ERR_NONE;
    if (q < MOD_W'(2))                                 s_e = ERR_BELOW2;
    else if (idx != '0 && q < prev_mod)                s_e = ERR_UNORDERED;
    else if ({1'b0, r} >= {q, 1'b0})                   s_e = ERR_ROOT;
    else if (flags_present && flag > FLAG_W'(1))       s_e = ERR_FLAG;

    if (pol == POL_GENERATED)
      kind_new = flagged ? (pw ? KIND_POWER : KIND_INVALID) : KIND_PRIME;
    else
      kind_new = pr ? KIND_PRIME : (pw ? KIND_POWER : KIND_INVALID);
    kind = need_class ? kind_new : cached_kind;

    c_e       = ERR_NONE;
    cache_upd = 1'b0;
    if (need_class) begin
      if (kind == KIND_INVALID)                          c_e = ERR_NOT_PP;
      else if (pol == POL_PRIMES && kind != KIND_PRIME)  c_e = ERR_POWER;
      else                                               cache_upd = (c_err == ERR_NONE);
    end
    if (c_e == ERR_NONE && flags_present && (flagged != (kind == KIND_POWER)))
      c_e = ERR_DISAGREE;

    s_err_next = s_err;
    s_at_next  = s_at;
    if (s_err == ERR_NONE && s_e != ERR_NONE) begin
      s_err_next = s_e;
      s_at_next  = idx;
    end
    c_err_next = c_err;
    c_at_next  = c_at;
    if (c_err == ERR_NONE && c_e != ERR_NONE) begin
      c_err_next = c_e;
      c_at_next  = idx;
    end

    code    = ERR_NONE;
    code_at = '0;
    if (policy == POL_GENERATED && !flags_present) begin
      code = ERR_FLAG;
    end else if (s_err_next != ERR_NONE) begin
      code    = s_err_next;
      code_at = s_at_next;
    end else if (c_err_next != ERR_NONE) begin
      code    = c_err_next;
      code_at = c_at_next;
    end
  end

  assign sts.need_loop = need_class && (c_err == ERR_NONE) &&
                         !(pol == POL_GENERATED && !flagged) &&
                         q[0] && (q >= MOD_W'(3));
  assign sts.dsq_over  = dsq > DSQ_W'(q);
  assign sts.div_done  = div_done;
  assign sts.rem_zero  = (rem == '0);
  assign sts.out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q       <= modulus;
      r       <= root_code;
      flag    <= power_flag;
      is_last <= last;
    end
    if (cmd.check) begin
      // quick answers for values the trial loop does not handle
      pr  <= (q == MOD_W'(2));
      pw  <= !q[0] && (q >= MOD_W'(4)) && ((q & (q - 1'b1)) == '0);
      d   <= DIV_W'(3);
      dsq <= DSQ_W'(9);
      w   <= q;
    end
    if (cmd.step_d) begin
      d   <= d + DIV_W'(2);
      dsq <= dsq + (DSQ_W'(d) << 2) + DSQ_W'(4);
    end
    if (cmd.take_quot) w <= quot;
    if (cmd.set_prime) begin
      pr <= 1'b1;
      pw <= 1'b0;
    end
    if (cmd.set_wres) begin
      pr <= 1'b0;
      pw <= (w == MOD_W'(1));
    end
    if (cmd.finish && is_last) begin
      passed      <= (code == ERR_NONE);
      error_code  <= code;
      error_index <= 32'(code_at);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      prev_mod    <= '0;
      idx         <= '0;
      s_err       <= ERR_NONE;
      s_at        <= '0;
      c_err       <= ERR_NONE;
      c_at        <= '0;
      cached_mod  <= '0;
      cached_kind <= KIND_INVALID;
      cache_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !(cmd.finish && is_last)) out_valid <= 1'b0;
      if (cmd.finish) begin
        if (is_last) begin
          out_valid   <= 1'b1;
          prev_mod    <= '0;
          idx         <= '0;
          s_err       <= ERR_NONE;
          s_at        <= '0;
          c_err       <= ERR_NONE;
          c_at        <= '0;
          cached_mod  <= '0;
          cached_kind <= KIND_INVALID;
          cache_valid <= 1'b0;
        end else begin
          prev_mod <= q;
          idx      <= idx + 1'b1;
          s_err    <= s_err_next;
          s_at     <= s_at_next;
          c_err    <= c_err_next;
          c_at     <= c_at_next;
          if (cache_upd) begin
            cached_mod  <= q;
            cached_kind <= kind;
            cache_valid <= 1'b1;
          end
        end
      end
    end
  end
endmodule

>>> hw/rtl/fbev_ctrl.sv
// controller: sequences entry load, trial division loop and verdict
// depends on fbev_pkg
module fbev_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              last_entry,
  input  fbev_pkg::status_t sts,
  output fbev_pkg::cmd_t    cmd
);
  import fbev_pkg::*;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = sts.need_loop ? S_TRIAL : S_FIN;
      end
      S_TRIAL: begin
        if (sts.dsq_over) begin
          cmd.set_prime = 1'b1;
          state_next    = S_FIN;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_TWAIT;
        end
      end
      S_TWAIT: begin
        if (sts.div_done) begin
          if (sts.rem_zero) begin
            cmd.take_quot = 1'b1;
            state_next    = S_STRIP;
          end else begin
            cmd.step_d = 1'b1;
            state_next = S_TRIAL;
          end
        end
      end
      S_STRIP: begin
        cmd.div_start = 1'b1;
        state_next    = S_SWAIT;
      end
      S_SWAIT: begin
        if (sts.div_done) begin
          if (sts.rem_zero) begin
            cmd.take_quot = 1'b1;
            state_next    = S_STRIP;
          end else begin
            cmd.set_wres = 1'b1;
            state_next   = S_FIN;
          end
        end
      end
      S_FIN: begin
        // a verdict waits for the output register to be free
        if (!last_entry || sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end
endmodule

>>> hw/rtl/factor_base_entry_validator.sv
// Factor base entry validator, top level.
// Entries arrive on the input channel (modulus, root_code, power_flag, last),
// one word accepted when in_valid is high and in_stall low. The block takes
// one entry at a time and raises in_stall while it works on it.
// Each entry is checked for structure and its modulus classified by trial
// division with a restoring divider; an entry whose modulus is cached or even
// skips the trial loop, which otherwise runs over the odd trial divisors.
// The entry marked last yields one result word (passed, error_code,
// error_index) held in an output register until out_stall is low; the next
// entry is accepted meanwhile, but the next verdict waits for that register.
// policy (address 0) and flags_present (address 4) are written over the APB
// port; the user must write them only while idle, the block does not enforce it.
// Reset (synchronous) clears all per-base state, empties the output
// register and sets policy to primes only with flags present.
// depends on fbev_pkg, fbev_ctrl, fbev_dpath
module factor_base_entry_validator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [fbev_pkg::MOD_W-1:0]  modulus,
  input  logic [fbev_pkg::ROOT_W-1:0] root_code,
  input  logic [fbev_pkg::FLAG_W-1:0] power_flag,
  input  logic                        last,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        passed,
  output logic [2:0]                  error_code,
  output logic [31:0]                 error_index
);
  import fbev_pkg::*;

  logic [1:0] policy;
  logic       flags_present;
  logic       cfg_wr;
  cmd_t       cmd;
  status_t    sts;
  logic       last_q;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy        <= POL_PRIMES;
      flags_present <= 1'b1;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_POLICY: policy        <= pwdata[1:0];
        REG_FLAGS:  flags_present <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_POLICY: prdata = {30'd0, policy};
      REG_FLAGS:  prdata = {31'd0, flags_present};
      default:    prdata = '0;
    endcase
  end

  // entry last bit kept for the controller's verdict wait
  always_ff @(posedge clk) begin
    if (cmd.load) last_q <= last;
  end

  fbev_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .last_entry(last_q),
    .sts       (sts),
    .cmd       (cmd)
  );

  fbev_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .policy       (policy),
    .flags_present(flags_present),
    .modulus      (modulus),
    .root_code    (root_code),
    .power_flag   (power_flag),
    .last         (last),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .passed       (passed),
    .error_code   (error_code),
    .error_index  (error_index)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("block not busy after accepting a word");

  a_pass_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && passed |-> error_code == ERR_NONE && error_index == 32'd0)
    else $error("passed verdict carries an error");

  a_fail_coded: assert property (@(posedge clk) disable iff (rst)
    out_valid && !passed |-> error_code != ERR_NONE)
    else $error("failed verdict without an error code");

  a_one_command: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.check, cmd.div_start, cmd.finish}))
    else $error("controller issued conflicting commands");
endmodule

>>> tb/testbench.sv
// self-checking testbench for factor_base_entry_validator
// depends on fbev_pkg and the validator rtl; checks every verdict against its own model
module testbench;
  import fbev_pkg::*;

  localparam logic [2:0] ADDR_POLICY = 3'd0;
  localparam logic [2:0] ADDR_FLAGS  = 3'd4;
  localparam int STALL_LIMIT = 200000;

  typedef struct {
    logic        passed;
    logic [2:0]  code;
    logic [31:0] at;
  } verdict_t;

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic in_valid, in_stall, last, out_valid, out_stall, passed;
  logic [31:0] modulus, root_code, error_index;
  logic [7:0] power_flag;
  logic [2:0] error_code;

  factor_base_entry_validator DUT (.*);

  // model state
  logic [31:0] prev_mod, entry_cnt, s_at, c_at, cache_mod;
  logic [2:0]  s_err, c_err;
  logic [1:0]  cache_kind, policy_reg;
  logic        cache_ok, flags_reg;

  verdict_t verdicts_due[$];
  int  errors;
  int  idle_cycles;
  bit  gaps_on, stalls_on;
  bit  in_taken;

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  function automatic bit is_prime(longint unsigned q);
    longint unsigned d;
    if (q < 2) return 0;
    if (q % 2 == 0) return q == 2;
    for (d = 3; d * d <= q; d += 2)
      if (q % d == 0) return 0;
    return 1;
  endfunction

  function automatic bit is_prime_power(longint unsigned q);
    longint unsigned d;
    if (q < 4) return 0;
    if (q % 2 == 0) begin
      while (q % 2 == 0) q = q / 2;
      return q == 1;
    end
    for (d = 3; d * d <= q; d += 2) begin
      if (q % d != 0) continue;
      while (q % d == 0) q = q / d;
      return q == 1;
    end
    return 0;
  endfunction

  function automatic void clear_base();
    prev_mod = 0; entry_cnt = 0; s_err = ERR_NONE; s_at = 0;
    c_err = ERR_NONE; c_at = 0; cache_mod = 0; cache_kind = KIND_INVALID; cache_ok = 0;
  endfunction

  function automatic void predict_entry(logic [31:0] q, logic [31:0] r, logic [7:0] f, logic l);
    logic [1:0] pol, kind;
    logic [2:0] e;
    logic flagged;
    verdict_t v;
    pol = (policy_reg == POL_UNKNOWN) ? POL_PRIMES : policy_reg;
    flagged = flags_reg && (f != 0);
    if (s_err == ERR_NONE) begin
      e = ERR_NONE;
      if (q < 2) e = ERR_BELOW2;
      else if (entry_cnt != 0 && q < prev_mod) e = ERR_UNORDERED;
      else if ({32'd0, r} >= 2 * {32'd0, q}) e = ERR_ROOT;
      else if (flags_reg && f > 1) e = ERR_FLAG;
      if (e != ERR_NONE) begin s_err = e; s_at = entry_cnt; end
    end
    prev_mod = q;
    if (c_err == ERR_NONE) begin
      kind = cache_kind;
      e = ERR_NONE;
      if (!cache_ok || q != cache_mod) begin
        if (pol == POL_GENERATED)
          kind = !flagged ? KIND_PRIME : (is_prime_power(q) ? KIND_POWER : KIND_INVALID);
        else if (is_prime(q)) kind = KIND_PRIME;
        else kind = is_prime_power(q) ? KIND_POWER : KIND_INVALID;
        if (kind == KIND_INVALID) e = ERR_NOT_PP;
        else if (pol == POL_PRIMES && kind != KIND_PRIME) e = ERR_POWER;
        else begin cache_mod = q; cache_kind = kind; cache_ok = 1; end
      end
      if (e == ERR_NONE && flags_reg && flagged != (kind == KIND_POWER)) e = ERR_DISAGREE;
      if (e != ERR_NONE) begin c_err = e; c_at = entry_cnt; end
    end
    entry_cnt = entry_cnt + 1;
    if (l) begin
      v.code = ERR_NONE; v.at = 0;
      if (policy_reg == POL_GENERATED && !flags_reg) v.code = ERR_FLAG;
      else if (s_err != ERR_NONE) begin v.code = s_err; v.at = s_at; end
      else if (c_err != ERR_NONE) begin v.code = c_err; v.at = c_at; end
      v.passed = (v.code == ERR_NONE);
      verdicts_due.push_back(v);
      clear_base();
    end
  endfunction

  function automatic int pick_gap();
    if (!gaps_on) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    return $urandom_range(0, 2);
  endfunction

  task automatic send_entry(logic [31:0] q, logic [31:0] r, logic [7:0] f, logic l);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    modulus <= q; root_code <= r; power_flag <= f; last <= l;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    predict_entry(q, r, f, l);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic set_config(logic [1:0] pol, logic fl);
    wait_idle();
    apb_write(ADDR_POLICY, {30'd0, pol});
    apb_write(ADDR_FLAGS, {31'd0, fl});
    policy_reg = pol;
    flags_reg = fl;
  endtask

  function automatic logic [31:0] pick_prime();
    logic [31:0] v;
    do v = $urandom_range(2, 3000); while (!is_prime(v));
    return v;
  endfunction

  function automatic logic [31:0] pick_power();
    longint unsigned p, v;
    int k;
    case ($urandom_range(0, 5))
      0: p = 2;
      1: p = 3;
      2: p = 5;
      3: p = 7;
      4: p = 13;
      default: p = 31;
    endcase
    v = p * p;
    k = $urandom_range(0, 30);
    while (k > 0 && v * p < 64'h1_0000_0000) begin v = v * p; k--; end
    return v[31:0];
  endfunction

  // small modulus or one with a small factor, so that trial division ends quickly
  function automatic logic [31:0] pick_noise_modulus();
    logic [31:0] v;
    case ($urandom_range(0, 3))
      0: v = $urandom_range(0, 5);
      1: v = {$urandom} & ~32'd1;
      2: v = ($urandom / 3) * 3;
      default: v = $urandom_range(2, 200);
    endcase
    return v;
  endfunction

  task automatic test_directed_primes();
    set_config(POL_PRIMES, 1'b1);
    send_entry(32'd0, 32'd0, 8'd0, 1'b1);
    send_entry(32'd2, 32'd3, 8'd0, 1'b0);
    send_entry(32'd7, 32'd13, 8'd0, 1'b0);
    send_entry(32'd7, 32'd0, 8'd0, 1'b1);
    send_entry(32'd5, 32'd1, 8'd0, 1'b0);
    send_entry(32'd3, 32'd1, 8'd0, 1'b0);
    send_entry(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1);
    send_entry(32'd11, 32'd22, 8'd0, 1'b1);
    send_entry(32'd13, 32'd0, 8'd2, 1'b1);
    send_entry(32'd15, 32'd0, 8'd0, 1'b1);
    send_entry(32'd9, 32'd0, 8'd1, 1'b1);
    send_entry(32'd17, 32'd0, 8'd1, 1'b1);
  endtask

  task automatic test_directed_powers();
    set_config(POL_EXTERNAL, 1'b1);
    send_entry(32'd9, 32'd17, 8'd1, 1'b0);
    send_entry(32'h8000_0000, 32'd0, 8'd1, 1'b0);
    send_entry(32'd3486784401, 32'hFFFF_FFFF, 8'd1, 1'b1);
    send_entry(32'd25, 32'd0, 8'd0, 1'b1);
    set_config(POL_GENERATED, 1'b1);
    send_entry(32'd6, 32'd0, 8'd0, 1'b0);
    send_entry(32'd8, 32'd0, 8'd1, 1'b0);
    send_entry(32'd12, 32'd0, 8'd1, 1'b1);
    set_config(POL_GENERATED, 1'b0);
    send_entry(32'd3, 32'd0, 8'd7, 1'b1);
    set_config(POL_UNKNOWN, 1'b0);
    send_entry(32'd4, 32'd0, 8'd200, 1'b1);
    set_config(POL_EXTERNAL, 1'b0);
    send_entry(32'd9, 32'd0, 8'd1, 1'b1);
  endtask

  task automatic send_random_base();
    logic [31:0] mods [8];
    logic [31:0] t, q, r;
    logic [7:0] f;
    int n, bad, i, j;
    bit pw;
    n = $urandom_range(1, 8);
    bad = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n - 1) : -1;
    for (i = 0; i < n; i++) begin
      pw = (policy_reg == POL_EXTERNAL || policy_reg == POL_GENERATED)
           && $urandom_range(0, 1);
      mods[i] = pw ? pick_power() : pick_prime();
      if (i > 0 && $urandom_range(0, 4) == 0) mods[i] = mods[i - 1];
    end
    for (i = 0; i < n; i++)
      for (j = 0; j + 1 < n - i; j++)
        if (mods[j] > mods[j + 1]) begin t = mods[j]; mods[j] = mods[j + 1]; mods[j + 1] = t; end
    for (i = 0; i < n; i++) begin
      q = mods[i];
      r = 32'(64'($urandom) % (64'd2 * 64'(q)));
      if (flags_reg) f = (is_prime(q) ? 8'd0 : 8'd1);
      else f = 8'($urandom);
      if (i == bad) begin
        case ($urandom_range(0, 3))
          0: q = pick_noise_modulus();
          1: r = $urandom;
          2: f = 8'($urandom);
          default: begin q = pick_noise_modulus(); r = $urandom; f = 8'($urandom); end
        endcase
      end
      send_entry(q, r, f, i == n - 1);
    end
  endtask

  task automatic test_random_bases();
    int sent;
    sent = 0;
    while (sent < 370) begin
      set_config(2'($urandom_range(0, 3)), ($urandom_range(0, 4) != 0));
      gaps_on = $urandom_range(0, 3) != 0;
      stalls_on = $urandom_range(0, 3) != 0;
      repeat ($urandom_range(4, 10)) begin
        send_random_base();
        sent = sent + int'(entry_cnt == 0);
      end
      sent = sent + 30;
    end
  endtask

  // hold the sender until every verdict has drained, then send back to back
  task automatic test_drain_then_burst();
    set_config(POL_EXTERNAL, 1'b1);
    gaps_on = 0;
    stalls_on = 1;
    wait_idle();
    repeat (6) send_random_base();
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    errors++;
  endtask

  // receiver stall, checker and watchdog
  int stall_left;
  bit stall_now;
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_now = stalls_on && $urandom_range(0, 2) == 0;
      stall_left = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 4);
    end else begin
      stall_left--;
    end
    out_stall <= stall_now;
  end

  always @(posedge clk) begin
    verdict_t v;
    if (!rst) begin
      in_taken = in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        if (verdicts_due.size() == 0) begin
          report_mismatch("verdict with none due", 32'd0, 32'd0);
        end else begin
          v = verdicts_due.pop_front();
          if (passed !== v.passed) report_mismatch("passed", 32'(passed), 32'(v.passed));
          if (error_code !== v.code)
            report_mismatch("error_code", 32'(error_code), 32'(v.code));
          if (error_index !== v.at) report_mismatch("error_index", error_index, v.at);
        end
      end
      if (in_taken || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    errors = 0; idle_cycles = 0; stall_left = 0; stall_now = 0;
    gaps_on = 1; stalls_on = 1;
    rst = 1'b1;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    in_valid = 0; modulus = 0; root_code = 0; power_flag = 0; last = 0; out_stall = 0;
    policy_reg = POL_PRIMES; flags_reg = 1'b1;
    clear_base();
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    // reset defaults: primes only, flags present
    send_entry(32'd3, 32'd5, 8'd0, 1'b0);
    send_entry(32'd4, 32'd1, 8'd1, 1'b1);
    test_directed_primes();
    test_directed_powers();
    test_random_bases();
    test_drain_then_burst();
    wait_idle();
    repeat (200) @(negedge clk);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
